// ===== rtl/hcd_pkg.sv =====
// ---------------------------------------------------------------------------
// hcd_pkg
// shared widths, register codes, reset values and multiplier types for the
// corner detector
// ---------------------------------------------------------------------------
package hcd_pkg;

   // default sizes
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int WINDOW_DEF     = 5;

   // item and register field widths
   localparam int CHAN_W     = 8;
   localparam int DIM_W      = 11;
   localparam int WT_W       = 8;
   localparam int THR_W      = 50;
   localparam int RESP_W     = 51;
   localparam int POS_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 50;

   // internal arithmetic widths
   localparam int PIX_W   = 10;
   localparam int GRAD_W  = 11;
   localparam int W2D_W   = 2 * WT_W;
   localparam int SUM_W   = 42;
   localparam int SHIFT_W = 8;
   localparam int MUL_W   = 34;
   localparam int MUL_STEP = 8;

   // register codes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH     = 3'd0,
      REG_HEIGHT    = 3'd1,
      REG_W_CENTER  = 3'd2,
      REG_W_NEAR    = 3'd3,
      REG_W_FAR     = 3'd4,
      REG_KAPPA     = 3'd5,
      REG_THRESHOLD = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic [DIM_W-1:0] RST_WIDTH     = 11'd640;
   localparam logic [DIM_W-1:0] RST_HEIGHT    = 11'd480;
   localparam logic [WT_W-1:0]  RST_W_CENTER  = 8'd102;
   localparam logic [WT_W-1:0]  RST_W_NEAR    = 8'd61;
   localparam logic [WT_W-1:0]  RST_W_FAR     = 8'd14;
   localparam logic [WT_W-1:0]  RST_KAPPA     = 8'd102;
   localparam logic [THR_W-1:0] RST_THRESHOLD = 50'd1000000;

   // smallest frame side
   localparam int MIN_DIM = 3;

   // serial multiplier handshake
   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] op_a;
      logic [MUL_W-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [2*MUL_W-1:0] product;
   } mul_rsp_type;

endpackage

// ===== rtl/hcd_channels.sv =====
// ---------------------------------------------------------------------------
// hcd channels
// valid/ready channel bundles for pixel items, result items and register
// writes
// ---------------------------------------------------------------------------
interface hcd_req_if import hcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, command, red, green, blue, input ready);
   modport sink (input valid, command, red, green, blue, output ready);
endinterface

interface hcd_rsp_if import hcd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     corner;
   logic [POS_W-1:0]         row;
   logic [POS_W-1:0]         column;
   logic                     last_of_frame;
   logic signed [RESP_W-1:0] response;

   modport source (output valid, corner, row, column, last_of_frame, response, input ready);
   modport sink (input valid, corner, row, column, last_of_frame, response, output ready);
endinterface

interface hcd_csr_if import hcd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/hcd_mul.sv =====
// ---------------------------------------------------------------------------
// hcd_mul
// unsigned shift-add multiplier, one operand byte per cycle, msb first
// ---------------------------------------------------------------------------
module hcd_mul import hcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   localparam int STEPS = (MUL_W + MUL_STEP - 1) / MUL_STEP;
   localparam int MPW   = STEPS * MUL_STEP;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [2*MUL_W-1:0]       acc_ff, acc_in;
   logic [MUL_W-1:0]         mcand_ff, mcand_in;
   logic [MPW-1:0]           mplier_ff, mplier_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [MUL_W+MUL_STEP-1:0] part;

   // one partial product per cycle
   assign part = mcand_ff * mplier_ff[MPW-1 -: MUL_STEP];

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (mul_req.start) begin
         acc_in    = '0;
         mcand_in  = mul_req.op_a;
         mplier_in = MPW'(mul_req.op_b);
         cnt_in    = CNT_W'(STEPS);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = (acc_ff << MUL_STEP) + (2*MUL_W)'(part);
         mplier_in = mplier_ff << MUL_STEP;
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

// ===== rtl/harris_corner_detector_unit.sv =====
// ---------------------------------------------------------------------------
// harris_corner_detector_unit
// streaming harris corner detector built round three line memories and one
// read-modify-write sequencer
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake      carries
//  req_chan  in   valid/ready    command, red, green, blue
//  rsp_chan  out  valid/ready    corner, row, column, last_of_frame, response
//  csr_chan  in   valid/ready    index, data (ready tied high)
//
//  items: one item at a time; a pixel item's time is set by the window sweep
//    over the gradient memory read port and the serial multiplier
//  reset: synchronous, active high; registers to defaults, item count to zero,
//    line memories are not cleared (every read hits an entry of this frame)
//  stalls: a new item is taken while a result waits on rsp_chan; only the
//    next result waits for the output register to empty
//
module harris_corner_detector_unit import hcd_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int WINDOW     = WINDOW_DEF
) (
   input logic   clock,
   input logic   reset,
   hcd_req_if.sink   req_chan,
   hcd_rsp_if.source rsp_chan,
   hcd_csr_if.sink   csr_chan
);

   // frame geometry widths
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + 4 * MAX_WIDTH + 4);
   localparam int XW = DIM_W + WW + HW;

   // ring sizes: each covers the span of entries still to be read
   localparam int PAW = $clog2(2 * MAX_WIDTH + 2);
   localparam int GAW = $clog2(4 * MAX_WIDTH + 5);
   localparam int RAW = $clog2(2 * MAX_WIDTH + 3);
   localparam int PDEPTH = 2 ** PAW;
   localparam int GDEPTH = 2 ** GAW;
   localparam int RDEPTH = 2 ** RAW;

   localparam int HALF  = (WINDOW - 1) / 2;
   localparam int WIN_CW = $clog2(WINDOW);
   localparam int VW = 2 * MUL_W + 2;

   localparam logic signed [VW-1:0] RESP_MAX_V = VW'({1'b0, {(RESP_W-1){1'b1}}});
   localparam logic signed [VW-1:0] RESP_MIN_V = -RESP_MAX_V - VW'(1);

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_DIMS, S_CHECK, S_GRD, S_GWR, S_RINIT, S_RWIN,
      S_RSCALE, S_RMS, S_RMW, S_RKAP, S_RFIN, S_OINIT, S_ONB, S_OUT, S_FIN
   } state_type;

   // config registers
   logic [DIM_W-1:0] width_cfg_ff, height_cfg_ff;
   logic [WT_W-1:0]  wc_ff, wn_ff, wf_ff, kappa_ff;
   logic [THR_W-1:0] thr_ff;

   // sequencer
   state_type state_ff, state_in;
   logic             cmd_ff, cmd_in;
   logic [PIX_W-1:0] pix_sum_ff, pix_sum_in;
   logic [TW-1:0]    items_ff, items_in;
   logic [WW-1:0]    fw_ff, fw_in;
   logic [HW-1:0]    fh_ff, fh_in;
   logic [TW-1:0]    n_ff, n_in, w3_ff, w3_in, w4_ff, w4_in;
   logic             gact_ff, gact_in, ract_ff, ract_in, oact_ff, oact_in;
   logic [TW-1:0]    gidx_ff, gidx_in, midx_ff, midx_in, kidx_ff, kidx_in;
   logic [RW-1:0]    gr_ff, gr_in, mr_ff, mr_in, kr_ff, kr_in;
   logic [CW-1:0]    gc_ff, gc_in, mc_ff, mc_in, kc_ff, kc_in;

   // gradient step
   logic [2:0]       grd_cnt_ff, grd_cnt_in;
   logic [PIX_W-1:0] pv_ff [4];
   logic [PIX_W-1:0] pv_in [4];

   // window sweep pipeline
   logic [WIN_CW-1:0] di_ff, di_in, dj_ff, dj_in;
   logic [GAW-1:0]    waddr_ff, waddr_in;
   logic              wiss_done_ff, wiss_done_in;
   logic              p1_vld_ff, p1_vld_in, p2_vld_ff, p2_vld_in, p3_vld_ff, p3_vld_in;
   logic [W2D_W-1:0]  w2d_p1_ff, w2d_p1_in, w2d_p2_ff, w2d_p2_in;
   logic signed [2*GRAD_W-1:0] sq_xx_ff, sq_xx_in, sq_xy_ff, sq_xy_in, sq_yy_ff, sq_yy_in;
   logic signed [SUM_W-1:0] wxx_ff, wxx_in, wxy_ff, wxy_in, wyy_ff, wyy_in;
   logic signed [SUM_W-1:0] sxx_ff, sxx_in, sxy_ff, sxy_in, syy_ff, syy_in;

   // response arithmetic
   logic [MUL_W-1:0]   ta_ff, ta_in, tc_ff, tc_in, tb_ff, tb_in, tt_sum_ff, tt_sum_in;
   logic [1:0]         mul_sel_ff, mul_sel_in;
   logic [2*MUL_W-1:0] ac_ff, ac_in, bb_ff, bb_in, tt_ff, tt_in, kt_ff, kt_in;

   // neighbour compare
   logic [1:0]     odi_ff, odi_in, odj_ff, odj_in;
   logic [RAW-1:0] oaddr_ff, oaddr_in;
   logic           oiss_done_ff, oiss_done_in;
   logic           o_vld_ff, o_vld_in, have_c_ff, have_c_in, nb_gt_ff, nb_gt_in;
   logic signed [RESP_W-1:0] rk_ff, rk_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_corner_ff, rsp_corner_in, rsp_last_ff, rsp_last_in;
   logic [POS_W-1:0]         rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic signed [RESP_W-1:0] rsp_resp_ff, rsp_resp_in;

   // memories
   logic [PIX_W-1:0]         pix_mem [PDEPTH];
   logic [2*GRAD_W-1:0]      grad_mem [GDEPTH];
   logic signed [RESP_W-1:0] resp_mem [RDEPTH];
   logic                     pix_we, grad_we, resp_we;
   logic [PAW-1:0]           pix_waddr, pix_raddr;
   logic [GAW-1:0]           grad_waddr, grad_raddr;
   logic [RAW-1:0]           resp_waddr, resp_raddr;
   logic [PIX_W-1:0]         pix_rdata;
   logic [2*GRAD_W-1:0]      grad_wdata, grad_rdata;
   logic signed [RESP_W-1:0] resp_wdata, resp_rdata;

   // multiplier
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   // helpers
   logic                 req_fire, rsp_fire;
   logic [XW-1:0]        w_ext, h_ext;
   logic [TW-1:0]        fw_t, g_diff, m_diff, k_diff;
   logic [RW+1:0]        win_rsum;
   logic [CW+1:0]        win_csum;
   logic                 win_inside;
   logic [RW+1:0]        nb_rsum;
   logic [CW+1:0]        nb_csum;
   logic                 nb_inside, nb_center;
   logic signed [GRAD_W-1:0] gdx, gdy, rdx, rdy;
   logic signed [SUM_W-1:0]  b_val;
   logic [2*MUL_W+WT_W-1:0]  kprod;
   logic signed [VW-1:0]     v_raw;
   logic signed [RESP_W-1:0] v_sat;
   logic                     out_last;

   function automatic logic [WT_W-1:0] pick_wt(input logic [WIN_CW-1:0] d,
                                                input logic [WT_W-1:0] wc,
                                                input logic [WT_W-1:0] wn,
                                                input logic [WT_W-1:0] wf);
      logic [WIN_CW-1:0] a;
      a = (d >= WIN_CW'(HALF)) ? d - WIN_CW'(HALF) : WIN_CW'(HALF) - d;
      if (a == WIN_CW'(0))
         return wc;
      else if (a == WIN_CW'(1))
         return wn;
      return wf;
   endfunction

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;

   // frame size clamp
   assign w_ext = XW'(width_cfg_ff);
   assign h_ext = XW'(height_cfg_ff);
   assign fw_t  = TW'(fw_ff);
   assign g_diff = items_ff - fw_t;
   assign m_diff = items_ff - w3_ff;
   assign k_diff = items_ff - w4_ff;

   // window position inside the frame
   assign win_rsum = (RW+2)'(mr_ff) + (RW+2)'(di_ff);
   assign win_csum = (CW+2)'(mc_ff) + (CW+2)'(dj_ff);
   assign win_inside = (win_rsum >= (RW+2)'(HALF)) &&
                       (win_rsum < (RW+2)'(fh_ff) + (RW+2)'(HALF)) &&
                       (win_csum >= (CW+2)'(HALF)) &&
                       (win_csum < (CW+2)'(fw_ff) + (CW+2)'(HALF));

   // neighbour position inside the frame
   assign nb_rsum = (RW+2)'(kr_ff) + (RW+2)'(odi_ff);
   assign nb_csum = (CW+2)'(kc_ff) + (CW+2)'(odj_ff);
   assign nb_center = (odi_ff == 2'd1) && (odj_ff == 2'd1);
   assign nb_inside = (nb_rsum >= (RW+2)'(1)) && (nb_rsum < (RW+2)'(fh_ff) + (RW+2)'(1)) &&
                      (nb_csum >= (CW+2)'(1)) && (nb_csum < (CW+2)'(fw_ff) + (CW+2)'(1));

   // central differences from the four captured channel sums
   assign gdx = $signed({1'b0, pv_ff[0]}) - $signed({1'b0, pv_ff[1]});
   assign gdy = $signed({1'b0, pv_ff[2]}) - $signed({1'b0, pv_ff[3]});
   assign rdx = $signed(grad_rdata[2*GRAD_W-1:GRAD_W]);
   assign rdy = $signed(grad_rdata[GRAD_W-1:0]);

   assign b_val = sxy_ff >>> SHIFT_W;
   assign kprod = tt_ff * kappa_ff;
   assign v_raw = $signed(VW'(ac_ff)) - $signed(VW'(bb_ff)) - $signed(VW'(kt_ff));
   assign v_sat = (v_raw > RESP_MAX_V) ? RESP_W'(RESP_MAX_V) :
                  (v_raw < RESP_MIN_V) ? RESP_W'(RESP_MIN_V) : RESP_W'(v_raw);
   assign out_last = (kidx_ff == n_ff - TW'(1));

   // multiplier operands
   always_comb begin
      mul_req.start = (state_ff == S_RMS);
      unique case (mul_sel_ff)
         2'd0: begin
            mul_req.op_a = ta_ff;
            mul_req.op_b = tc_ff;
         end
         2'd1: begin
            mul_req.op_a = tb_ff;
            mul_req.op_b = tb_ff;
         end
         default: begin
            mul_req.op_a = tt_sum_ff;
            mul_req.op_b = tt_sum_ff;
         end
      endcase
   end

   hcd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pix_sum_in   = pix_sum_ff;
      items_in     = items_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      n_in         = n_ff;
      w3_in        = w3_ff;
      w4_in        = w4_ff;
      gact_in      = gact_ff;
      ract_in      = ract_ff;
      oact_in      = oact_ff;
      gidx_in      = gidx_ff;
      midx_in      = midx_ff;
      kidx_in      = kidx_ff;
      gr_in        = gr_ff;
      gc_in        = gc_ff;
      mr_in        = mr_ff;
      mc_in        = mc_ff;
      kr_in        = kr_ff;
      kc_in        = kc_ff;
      grd_cnt_in   = grd_cnt_ff;
      pv_in        = pv_ff;
      di_in        = di_ff;
      dj_in        = dj_ff;
      waddr_in     = waddr_ff;
      wiss_done_in = wiss_done_ff;
      p1_vld_in    = 1'b0;
      w2d_p1_in    = w2d_p1_ff;
      p2_vld_in    = p1_vld_ff;
      w2d_p2_in    = w2d_p1_ff;
      sq_xx_in     = rdx * rdx;
      sq_xy_in     = rdx * rdy;
      sq_yy_in     = rdy * rdy;
      p3_vld_in    = p2_vld_ff;
      wxx_in       = sq_xx_ff * $signed({1'b0, w2d_p2_ff});
      wxy_in       = sq_xy_ff * $signed({1'b0, w2d_p2_ff});
      wyy_in       = sq_yy_ff * $signed({1'b0, w2d_p2_ff});
      sxx_in       = sxx_ff;
      sxy_in       = sxy_ff;
      syy_in       = syy_ff;
      ta_in        = ta_ff;
      tc_in        = tc_ff;
      tb_in        = tb_ff;
      tt_sum_in    = tt_sum_ff;
      mul_sel_in   = mul_sel_ff;
      ac_in        = ac_ff;
      bb_in        = bb_ff;
      tt_in        = tt_ff;
      kt_in        = kt_ff;
      odi_in       = odi_ff;
      odj_in       = odj_ff;
      oaddr_in     = oaddr_ff;
      oiss_done_in = oiss_done_ff;
      o_vld_in     = 1'b0;
      have_c_in    = have_c_ff;
      nb_gt_in     = nb_gt_ff;
      rk_in        = rk_ff;
      rsp_valid_in  = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_corner_in = rsp_corner_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_resp_in   = rsp_resp_ff;

      pix_we     = 1'b0;
      pix_waddr  = items_ff[PAW-1:0];
      pix_raddr  = gidx_ff[PAW-1:0];
      grad_we    = 1'b0;
      grad_waddr = gidx_ff[GAW-1:0];
      grad_wdata = {gdx, gdy};
      grad_raddr = waddr_ff;
      resp_we    = 1'b0;
      resp_waddr = midx_ff[RAW-1:0];
      resp_wdata = v_sat;
      resp_raddr = oaddr_ff;

      // accumulate whatever the window pipeline delivers
      if (p3_vld_ff) begin
         sxx_in = sxx_ff + wxx_ff;
         sxy_in = sxy_ff + wxy_ff;
         syy_in = syy_ff + wyy_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_chan.command;
               pix_sum_in = PIX_W'(req_chan.red) + PIX_W'(req_chan.green) +
                            PIX_W'(req_chan.blue);
               state_in   = S_START;
            end
         end

         S_START: begin
            if (items_ff != '0) begin
               state_in = S_CHECK;
            end else if (cmd_ff) begin
               // drain before any pixel: dropped
               state_in = S_IDLE;
            end else begin
               if (w_ext < XW'(MIN_DIM))
                  fw_in = WW'(MIN_DIM);
               else if (w_ext > XW'(MAX_WIDTH))
                  fw_in = WW'(MAX_WIDTH);
               else
                  fw_in = WW'(width_cfg_ff);
               if (h_ext < XW'(MIN_DIM))
                  fh_in = HW'(MIN_DIM);
               else if (h_ext > XW'(MAX_HEIGHT))
                  fh_in = HW'(MAX_HEIGHT);
               else
                  fh_in = HW'(height_cfg_ff);
               state_in = S_DIMS;
            end
         end

         S_DIMS: begin
            n_in  = TW'(fw_ff * fh_ff);
            w3_in = TW'(3) * fw_t + TW'(2);
            w4_in = TW'(4) * fw_t + TW'(3);
            gr_in = '0;
            gc_in = '0;
            mr_in = '0;
            mc_in = '0;
            kr_in = '0;
            kc_in = '0;
            state_in = S_CHECK;
         end

         S_CHECK: begin
            if (items_ff < n_ff && cmd_ff) begin
               // drain while pixels are still due: dropped
               state_in = S_IDLE;
            end else begin
               pix_we  = (items_ff < n_ff);
               gact_in = (items_ff >= fw_t) && (g_diff < n_ff);
               ract_in = (items_ff >= w3_ff) && (m_diff < n_ff);
               oact_in = (items_ff >= w4_ff) && (k_diff < n_ff);
               gidx_in = g_diff;
               midx_in = m_diff;
               kidx_in = k_diff;
               grd_cnt_in = '0;
               state_in = ((items_ff >= fw_t) && (g_diff < n_ff)) ? S_GRD : S_RINIT;
            end
         end

         S_GRD: begin
            // right, left, below, above with edge replication
            unique case (grd_cnt_ff)
               3'd0: pix_raddr = (WW'(gc_ff) + WW'(1) < fw_ff) ?
                                 gidx_ff[PAW-1:0] + PAW'(1) : gidx_ff[PAW-1:0];
               3'd1: pix_raddr = (gc_ff != '0) ?
                                 gidx_ff[PAW-1:0] - PAW'(1) : gidx_ff[PAW-1:0];
               3'd2: pix_raddr = (HW'(gr_ff) + HW'(1) < fh_ff) ?
                                 gidx_ff[PAW-1:0] + PAW'(fw_ff) : gidx_ff[PAW-1:0];
               3'd3: pix_raddr = (gr_ff != '0) ?
                                 gidx_ff[PAW-1:0] - PAW'(fw_ff) : gidx_ff[PAW-1:0];
               default: pix_raddr = gidx_ff[PAW-1:0];
            endcase
            if (grd_cnt_ff != 3'd0)
               pv_in[2'(grd_cnt_ff - 3'd1)] = pix_rdata;
            grd_cnt_in = grd_cnt_ff + 3'd1;
            if (grd_cnt_ff == 3'd4)
               state_in = S_GWR;
         end

         S_GWR: begin
            grad_we = 1'b1;
            if (WW'(gc_ff) == fw_ff - WW'(1)) begin
               gc_in = '0;
               gr_in = gr_ff + RW'(1);
            end else begin
               gc_in = gc_ff + CW'(1);
            end
            state_in = S_RINIT;
         end

         S_RINIT: begin
            if (!ract_ff) begin
               state_in = S_OINIT;
            end else begin
               di_in        = '0;
               dj_in        = '0;
               waddr_in     = midx_ff[GAW-1:0] - GAW'(HALF) * GAW'(fw_ff) - GAW'(HALF);
               wiss_done_in = 1'b0;
               sxx_in       = '0;
               sxy_in       = '0;
               syy_in       = '0;
               state_in     = S_RWIN;
            end
         end

         S_RWIN: begin
            // issue one window read per cycle, skip positions off the frame
            if (!wiss_done_ff) begin
               p1_vld_in = win_inside;
               w2d_p1_in = pick_wt(di_ff, wc_ff, wn_ff, wf_ff) *
                           pick_wt(dj_ff, wc_ff, wn_ff, wf_ff);
               if (dj_ff == WIN_CW'(WINDOW - 1)) begin
                  dj_in    = '0;
                  di_in    = di_ff + WIN_CW'(1);
                  waddr_in = waddr_ff + GAW'(fw_ff) - GAW'(WINDOW - 1);
                  if (di_ff == WIN_CW'(WINDOW - 1))
                     wiss_done_in = 1'b1;
               end else begin
                  dj_in    = dj_ff + WIN_CW'(1);
                  waddr_in = waddr_ff + GAW'(1);
               end
            end else if (!p1_vld_ff && !p2_vld_ff && !p3_vld_ff) begin
               state_in = S_RSCALE;
            end
         end

         S_RSCALE: begin
            ta_in      = MUL_W'(sxx_ff[SUM_W-1:SHIFT_W]);
            tc_in      = MUL_W'(syy_ff[SUM_W-1:SHIFT_W]);
            tb_in      = MUL_W'(b_val[SUM_W-1] ? -b_val : b_val);
            tt_sum_in  = MUL_W'(sxx_ff[SUM_W-1:SHIFT_W]) + MUL_W'(syy_ff[SUM_W-1:SHIFT_W]);
            mul_sel_in = 2'd0;
            state_in   = S_RMS;
         end

         S_RMS: begin
            state_in = S_RMW;
         end

         S_RMW: begin
            if (mul_rsp.done) begin
               unique case (mul_sel_ff)
                  2'd0: ac_in = mul_rsp.product;
                  2'd1: bb_in = mul_rsp.product;
                  default: tt_in = mul_rsp.product;
               endcase
               if (mul_sel_ff == 2'd2) begin
                  state_in = S_RKAP;
               end else begin
                  mul_sel_in = mul_sel_ff + 2'd1;
                  state_in   = S_RMS;
               end
            end
         end

         S_RKAP: begin
            kt_in    = kprod[2*MUL_W+WT_W-1:SHIFT_W];
            state_in = S_RFIN;
         end

         S_RFIN: begin
            resp_we = 1'b1;
            if (WW'(mc_ff) == fw_ff - WW'(1)) begin
               mc_in = '0;
               mr_in = mr_ff + RW'(1);
            end else begin
               mc_in = mc_ff + CW'(1);
            end
            state_in = S_OINIT;
         end

         S_OINIT: begin
            if (!oact_ff) begin
               state_in = S_FIN;
            end else begin
               resp_raddr   = kidx_ff[RAW-1:0];
               o_vld_in     = 1'b1;
               have_c_in    = 1'b0;
               nb_gt_in     = 1'b0;
               odi_in       = '0;
               odj_in       = '0;
               oaddr_in     = kidx_ff[RAW-1:0] - RAW'(fw_ff) - RAW'(1);
               oiss_done_in = 1'b0;
               state_in     = S_ONB;
            end
         end

         S_ONB: begin
            // first word back is the pixel itself, then its neighbours
            if (o_vld_ff) begin
               if (!have_c_ff) begin
                  rk_in     = resp_rdata;
                  have_c_in = 1'b1;
               end else if (resp_rdata > rk_ff) begin
                  nb_gt_in = 1'b1;
               end
            end
            if (!oiss_done_ff) begin
               o_vld_in = nb_inside && !nb_center;
               if (odj_ff == 2'd2) begin
                  odj_in   = '0;
                  odi_in   = odi_ff + 2'd1;
                  oaddr_in = oaddr_ff + RAW'(fw_ff) - RAW'(2);
                  if (odi_ff == 2'd2)
                     oiss_done_in = 1'b1;
               end else begin
                  odj_in   = odj_ff + 2'd1;
                  oaddr_in = oaddr_ff + RAW'(1);
               end
            end else if (!o_vld_ff) begin
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_corner_in = (rk_ff > $signed({1'b0, thr_ff})) && !nb_gt_ff;
               rsp_row_in    = POS_W'(kr_ff);
               rsp_col_in    = POS_W'(kc_ff);
               rsp_last_in   = out_last;
               rsp_resp_in   = rk_ff;
               items_in      = out_last ? '0 : items_ff + TW'(1);
               if (WW'(kc_ff) == fw_ff - WW'(1)) begin
                  kc_in = '0;
                  kr_in = kr_ff + RW'(1);
               end else begin
                  kc_in = kc_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end

         S_FIN: begin
            items_in = items_ff + TW'(1);
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         items_ff      <= '0;
         fw_ff         <= WW'(MIN_DIM);
         fh_ff         <= HW'(MIN_DIM);
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         p3_vld_ff     <= 1'b0;
         o_vld_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         width_cfg_ff  <= RST_WIDTH;
         height_cfg_ff <= RST_HEIGHT;
         wc_ff         <= RST_W_CENTER;
         wn_ff         <= RST_W_NEAR;
         wf_ff         <= RST_W_FAR;
         kappa_ff      <= RST_KAPPA;
         thr_ff        <= RST_THRESHOLD;
      end else begin
         state_ff     <= state_in;
         items_ff     <= items_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         p3_vld_ff    <= p3_vld_in;
         o_vld_ff     <= o_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            unique case (csr_index_type'(csr_chan.index))
               REG_WIDTH:     width_cfg_ff  <= csr_chan.data[DIM_W-1:0];
               REG_HEIGHT:    height_cfg_ff <= csr_chan.data[DIM_W-1:0];
               REG_W_CENTER:  wc_ff         <= csr_chan.data[WT_W-1:0];
               REG_W_NEAR:    wn_ff         <= csr_chan.data[WT_W-1:0];
               REG_W_FAR:     wf_ff         <= csr_chan.data[WT_W-1:0];
               REG_KAPPA:     kappa_ff      <= csr_chan.data[WT_W-1:0];
               REG_THRESHOLD: thr_ff        <= csr_chan.data[THR_W-1:0];
               default: ;
            endcase
         end
      end
      cmd_ff        <= cmd_in;
      pix_sum_ff    <= pix_sum_in;
      n_ff          <= n_in;
      w3_ff         <= w3_in;
      w4_ff         <= w4_in;
      gact_ff       <= gact_in;
      ract_ff       <= ract_in;
      oact_ff       <= oact_in;
      gidx_ff       <= gidx_in;
      midx_ff       <= midx_in;
      kidx_ff       <= kidx_in;
      gr_ff         <= gr_in;
      gc_ff         <= gc_in;
      mr_ff         <= mr_in;
      mc_ff         <= mc_in;
      kr_ff         <= kr_in;
      kc_ff         <= kc_in;
      grd_cnt_ff    <= grd_cnt_in;
      pv_ff         <= pv_in;
      di_ff         <= di_in;
      dj_ff         <= dj_in;
      waddr_ff      <= waddr_in;
      wiss_done_ff  <= wiss_done_in;
      w2d_p1_ff     <= w2d_p1_in;
      w2d_p2_ff     <= w2d_p2_in;
      sq_xx_ff      <= sq_xx_in;
      sq_xy_ff      <= sq_xy_in;
      sq_yy_ff      <= sq_yy_in;
      wxx_ff        <= wxx_in;
      wxy_ff        <= wxy_in;
      wyy_ff        <= wyy_in;
      sxx_ff        <= sxx_in;
      sxy_ff        <= sxy_in;
      syy_ff        <= syy_in;
      ta_ff         <= ta_in;
      tc_ff         <= tc_in;
      tb_ff         <= tb_in;
      tt_sum_ff     <= tt_sum_in;
      mul_sel_ff    <= mul_sel_in;
      ac_ff         <= ac_in;
      bb_ff         <= bb_in;
      tt_ff         <= tt_in;
      kt_ff         <= kt_in;
      odi_ff        <= odi_in;
      odj_ff        <= odj_in;
      oaddr_ff      <= oaddr_in;
      oiss_done_ff  <= oiss_done_in;
      have_c_ff     <= have_c_in;
      nb_gt_ff      <= nb_gt_in;
      rk_ff         <= rk_in;
      rsp_corner_ff <= rsp_corner_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_resp_ff   <= rsp_resp_in;
   end

   // channel sum line memory
   always_ff @(posedge clock) begin
      if (pix_we)
         pix_mem[pix_waddr] <= pix_sum_ff;
      pix_rdata <= pix_mem[pix_raddr];
   end

   // gradient line memory
   always_ff @(posedge clock) begin
      if (grad_we)
         grad_mem[grad_waddr] <= grad_wdata;
      grad_rdata <= grad_mem[grad_raddr];
   end

   // response line memory
   always_ff @(posedge clock) begin
      if (resp_we)
         resp_mem[resp_waddr] <= resp_wdata;
      resp_rdata <= resp_mem[resp_raddr];
   end

   // ports
   assign req_chan.ready      = (state_ff == S_IDLE);
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.corner     = rsp_corner_ff;
   assign rsp_chan.row        = rsp_row_ff;
   assign rsp_chan.column     = rsp_col_ff;
   assign rsp_chan.last_of_frame = rsp_last_ff;
   assign rsp_chan.response   = rsp_resp_ff;

   // multiplier only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == S_RMW)
      else $error("multiplier result outside wait state");

   // window pipeline data only flows during the window sweep
   assert property (@(posedge clock) disable iff (reset)
      p1_vld_ff |-> state_ff == S_RWIN)
      else $error("window read outside sweep");

   // item count restarts after the frame's final result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && state_in == S_IDLE && out_last) |=> items_ff == '0)
      else $error("item count not cleared at frame end");

endmodule
